[hdl/ucrr_pkg.sv]
// ----------------------------------------------------------------------------
// ucrr_pkg
// Shared constants, microcode format, microprogram and descriptor contents
// for the endpoint zero standard request responder.
// ----------------------------------------------------------------------------
package ucrr_pkg;

	localparam int EP0_PACKET_BYTES = 32;
	localparam int PKT_W = $clog2(EP0_PACKET_BYTES);
	localparam int ROM_BYTES = 52;
	localparam int PTR_W = 6;
	localparam int CNT_W = 6;
	localparam int PC_W = 4;
	localparam int PADDR_W = 3;

	localparam logic [PTR_W-1:0] DEV_OFS = 6'd0;
	localparam logic [CNT_W-1:0] DEV_LEN = 6'd18;
	localparam logic [PTR_W-1:0] CFG_OFS = 6'd18;
	localparam logic [CNT_W-1:0] CFG_LEN = 6'd34;

	localparam logic [15:0] VEND_CODE_RST = 16'h03EB;
	localparam logic [15:0] PROD_CODE_RST = 16'h2FF4;

	localparam logic [1:0] KIND_DATA = 2'd0;
	localparam logic [1:0] KIND_ZLP = 2'd1;
	localparam logic [1:0] KIND_STALL = 2'd2;
	localparam logic [1:0] KIND_DONE = 2'd3;

	localparam logic [7:0] REQ_GET_STATUS = 8'h00;
	localparam logic [7:0] REQ_SET_ADDRESS = 8'h05;
	localparam logic [7:0] REQ_GET_DESCRIPTOR = 8'h06;
	localparam logic [7:0] REQ_GET_CONFIGURATION = 8'h08;
	localparam logic [7:0] REQ_SET_CONFIGURATION = 8'h09;
	localparam logic [7:0] RT_HOST_TO_DEV = 8'h00;
	localparam logic [7:0] RT_DEV_TO_HOST = 8'h80;
	localparam logic [7:0] DT_DEVICE = 8'h01;
	localparam logic [7:0] DT_CONFIGURATION = 8'h02;

	localparam logic REG_VEND_CODE = 1'b0;
	localparam logic REG_PROD_CODE = 1'b1;

	localparam logic [PC_W-1:0] UA_DISPATCH = 4'd0;
	localparam logic [PC_W-1:0] UA_BUSRST = 4'd1;
	localparam logic [PC_W-1:0] UA_STALL = 4'd2;
	localparam logic [PC_W-1:0] UA_DONE = 4'd3;
	localparam logic [PC_W-1:0] UA_SETADDR = 4'd4;
	localparam logic [PC_W-1:0] UA_SETCFG = 4'd5;
	localparam logic [PC_W-1:0] UA_GETCFG = 4'd6;
	localparam logic [PC_W-1:0] UA_STAT0 = 4'd7;
	localparam logic [PC_W-1:0] UA_STAT1 = 4'd8;
	localparam logic [PC_W-1:0] UA_DESC = 4'd9;

	localparam logic [1:0] DS_ZERO = 2'd0;
	localparam logic [1:0] DS_CFG = 2'd1;
	localparam logic [1:0] DS_ROM = 2'd2;

	localparam logic [1:0] PS_ZERO = 2'd0;
	localparam logic [1:0] PS_ONE = 2'd1;
	localparam logic [1:0] PS_PKT = 2'd2;

	localparam logic [1:0] LS_ZERO = 2'd0;
	localparam logic [1:0] LS_ONE = 2'd1;
	localparam logic [1:0] LS_FIN = 2'd2;

	localparam logic [1:0] WR_NONE = 2'd0;
	localparam logic [1:0] WR_CLEAR = 2'd1;
	localparam logic [1:0] WR_ADDR = 2'd2;
	localparam logic [1:0] WR_CFG = 2'd3;

	localparam logic [1:0] NX_DISPATCH = 2'd0;
	localparam logic [1:0] NX_NEXT = 2'd1;
	localparam logic [1:0] NX_LOOP = 2'd2;
	localparam logic [1:0] NX_IDLE = 2'd3;

	typedef struct packed {
		logic emit;
		logic [1:0] kind;
		logic [1:0] dsrc;
		logic [1:0] pend;
		logic [1:0] lst;
		logic [1:0] wr;
		logic [1:0] nxt;
	} ucw_t;

	localparam logic [7:0] ROM_INIT [ROM_BYTES] = '{
		8'd18, 8'h01, 8'h00, 8'h02, 8'h00, 8'h00, 8'h00, 8'(EP0_PACKET_BYTES),
		8'hEB, 8'h03, 8'hF4, 8'h2F, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h01,
		8'd9, 8'h02, 8'd34, 8'h00, 8'h01, 8'h01, 8'h00, 8'hC0, 8'd50,
		8'd9, 8'h04, 8'h00, 8'h00, 8'h01, 8'h03, 8'h01, 8'h01, 8'h00,
		8'd7, 8'h05, 8'h81, 8'h03, 8'h08, 8'h00, 8'h0A,
		8'd9, 8'h21, 8'h01, 8'h01, 8'h00, 8'h01, 8'h22, 8'h3F, 8'h00
	};

	function automatic ucw_t ucode(input logic [PC_W-1:0] pc);
		ucw_t w;
		w = '{emit: 1'b1, kind: KIND_STALL, dsrc: DS_ZERO, pend: PS_ZERO,
			lst: LS_ONE, wr: WR_NONE, nxt: NX_IDLE};
		unique case (pc)
			UA_DISPATCH: begin
				w.emit = 1'b0;
				w.nxt = NX_DISPATCH;
			end
			UA_BUSRST: begin
				w.kind = KIND_DONE;
				w.wr = WR_CLEAR;
			end
			UA_STALL: begin
				w.kind = KIND_STALL;
			end
			UA_DONE: begin
				w.kind = KIND_DONE;
			end
			UA_SETADDR: begin
				w.kind = KIND_ZLP;
				w.pend = PS_ONE;
				w.wr = WR_ADDR;
			end
			UA_SETCFG: begin
				w.kind = KIND_ZLP;
				w.pend = PS_ONE;
				w.wr = WR_CFG;
			end
			UA_GETCFG: begin
				w.kind = KIND_DATA;
				w.dsrc = DS_CFG;
				w.pend = PS_ONE;
			end
			UA_STAT0: begin
				w.kind = KIND_DATA;
				w.lst = LS_ZERO;
				w.nxt = NX_NEXT;
			end
			UA_STAT1: begin
				w.kind = KIND_DATA;
				w.pend = PS_ONE;
			end
			UA_DESC: begin
				w.kind = KIND_DATA;
				w.dsrc = DS_ROM;
				w.pend = PS_PKT;
				w.lst = LS_FIN;
				w.nxt = NX_LOOP;
			end
			default: begin
				w.kind = KIND_STALL;
			end
		endcase
		return w;
	endfunction

	function automatic logic [7:0] rom_byte(input logic [PTR_W-1:0] idx,
		input logic [15:0] vid, input logic [15:0] pid);
		logic [7:0] b;
		b = 8'h00;
		if (idx < PTR_W'(ROM_BYTES)) begin
			b = ROM_INIT[idx];
		end
		if (idx == 6'd8) begin
			b = vid[7:0];
		end
		if (idx == 6'd9) begin
			b = vid[15:8];
		end
		if (idx == 6'd10) begin
			b = pid[7:0];
		end
		if (idx == 6'd11) begin
			b = pid[15:8];
		end
		return b;
	endfunction

endpackage

[hdl/ucrr_req_if.sv]
// ----------------------------------------------------------------------------
// ucrr_req_if
// Request channel: decoded setup packets and bus reset events.
// ----------------------------------------------------------------------------
interface ucrr_req_if;
	logic valid;
	logic ready;
	logic cmd;
	logic [7:0] request_type;
	logic [7:0] request;
	logic [15:0] req_value;
	logic [15:0] req_index;
	logic [15:0] req_length;

	modport source(output valid, cmd, request_type, request, req_value, req_index,
		req_length, input ready);
	modport sink(input valid, cmd, request_type, request, req_value, req_index,
		req_length, output ready);
endinterface

[hdl/ucrr_rsp_if.sv]
// ----------------------------------------------------------------------------
// ucrr_rsp_if
// Response channel: data bytes, zero-length packets, stalls and completions.
// ----------------------------------------------------------------------------
interface ucrr_rsp_if;
	logic valid;
	logic ready;
	logic [1:0] kind;
	logic [7:0] data_byte;
	logic packet_end;
	logic last;
	logic [6:0] device_address;
	logic address_enabled;
	logic [7:0] config_value;

	modport source(output valid, kind, data_byte, packet_end, last, device_address,
		address_enabled, config_value, input ready);
	modport sink(input valid, kind, data_byte, packet_end, last, device_address,
		address_enabled, config_value, output ready);
endinterface

[hdl/usb_control_request_responder_unit.sv]
// ----------------------------------------------------------------------------
// usb_control_request_responder_unit
// Endpoint zero standard request handler driven by a small microprogram.
// ----------------------------------------------------------------------------
// Channel  Direction  Contents
// req      in         setup packet fields or bus reset event
// rsp      out        one result per transaction, last marks the final one
// apb      in         vendor code at 0x0, product code at 0x4
//
// A request is taken in the dispatch step and then runs one microcode step per
// result, so a descriptor reply takes one step per byte.
// An output register holds each result; a stalled rsp channel holds the step.
// Reset clears the address, configuration and sequencer; no clearing pass.
// ----------------------------------------------------------------------------
module usb_control_request_responder_unit (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [ucrr_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	ucrr_req_if.sink req,
	ucrr_rsp_if.source rsp
);

	logic [15:0] vend_code_q;
	logic [15:0] prod_code_q;
	logic [ucrr_pkg::PC_W-1:0] pc_q;
	logic [7:0] val_q;
	logic [ucrr_pkg::CNT_W-1:0] cnt_q;
	logic [ucrr_pkg::PTR_W-1:0] ptr_q;
	logic [ucrr_pkg::PKT_W-1:0] pkt_q;
	logic [7:0] cfg_q;
	logic [6:0] addr_q;
	logic aen_q;
	logic rsp_valid_q;
	logic [1:0] kind_q;
	logic [7:0] data_q;
	logic pend_q;
	logic last_q;
	logic [6:0] addr_out_q;
	logic aen_out_q;
	logic [7:0] cfg_out_q;

	ucrr_pkg::ucw_t cw;
	logic out_free;
	logic fire;
	logic in_acc;
	logic fin;
	logic pkt_full;
	logic pend_bit;
	logic last_bit;
	logic [7:0] data_bit;
	logic [7:0] cfg_nx;
	logic [6:0] addr_nx;
	logic aen_nx;
	logic [ucrr_pkg::PC_W-1:0] entry;
	logic [ucrr_pkg::CNT_W-1:0] dsize;
	logic [ucrr_pkg::PTR_W-1:0] dbase;
	logic [ucrr_pkg::CNT_W-1:0] dcnt;
	logic apb_wr;

	assign pready = 1'b1;
	assign apb_wr = psel && penable && pwrite;
	assign prdata = (paddr[2] == ucrr_pkg::REG_PROD_CODE) ? {16'h0000, prod_code_q}
		: {16'h0000, vend_code_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vend_code_q <= ucrr_pkg::VEND_CODE_RST;
			prod_code_q <= ucrr_pkg::PROD_CODE_RST;
		end else if (apb_wr) begin
			if (paddr[2] == ucrr_pkg::REG_PROD_CODE) begin
				prod_code_q <= pwdata[15:0];
			end else begin
				vend_code_q <= pwdata[15:0];
			end
		end
	end

	assign cw = ucrr_pkg::ucode(pc_q);
	assign out_free = !rsp_valid_q || rsp.ready;
	assign fire = cw.emit && out_free;
	assign req.ready = (pc_q == ucrr_pkg::UA_DISPATCH);
	assign in_acc = req.valid && req.ready;

	always_comb begin
		dsize = ucrr_pkg::DEV_LEN;
		dbase = ucrr_pkg::DEV_OFS;
		if (req.req_value[15:8] == ucrr_pkg::DT_CONFIGURATION) begin
			dsize = ucrr_pkg::CFG_LEN;
			dbase = ucrr_pkg::CFG_OFS;
		end
		dcnt = (req.req_length >= 16'(dsize)) ? dsize : req.req_length[ucrr_pkg::CNT_W-1:0];
	end

	always_comb begin
		entry = ucrr_pkg::UA_STALL;
		priority if (req.cmd) begin
			entry = ucrr_pkg::UA_BUSRST;
		end else if (req.request == ucrr_pkg::REQ_GET_DESCRIPTOR
			&& req.request_type == ucrr_pkg::RT_DEV_TO_HOST) begin
			if (req.req_value[15:8] == ucrr_pkg::DT_DEVICE
				|| req.req_value[15:8] == ucrr_pkg::DT_CONFIGURATION) begin
				entry = (dcnt == '0) ? ucrr_pkg::UA_DONE : ucrr_pkg::UA_DESC;
			end else begin
				entry = ucrr_pkg::UA_STALL;
			end
		end else if (req.request == ucrr_pkg::REQ_SET_ADDRESS
			&& req.request_type == ucrr_pkg::RT_HOST_TO_DEV) begin
			entry = ucrr_pkg::UA_SETADDR;
		end else if (req.request == ucrr_pkg::REQ_SET_CONFIGURATION
			&& req.request_type == ucrr_pkg::RT_HOST_TO_DEV) begin
			entry = ucrr_pkg::UA_SETCFG;
		end else if (req.request == ucrr_pkg::REQ_GET_CONFIGURATION
			&& req.request_type == ucrr_pkg::RT_DEV_TO_HOST) begin
			entry = ucrr_pkg::UA_GETCFG;
		end else if (req.request == ucrr_pkg::REQ_GET_STATUS) begin
			entry = ucrr_pkg::UA_STAT0;
		end else begin
			entry = ucrr_pkg::UA_STALL;
		end
	end

	assign fin = (cnt_q == ucrr_pkg::CNT_W'(1));
	assign pkt_full = (pkt_q == ucrr_pkg::PKT_W'(ucrr_pkg::EP0_PACKET_BYTES - 1));

	always_comb begin
		unique case (cw.pend)
			ucrr_pkg::PS_ONE: pend_bit = 1'b1;
			ucrr_pkg::PS_PKT: pend_bit = fin || pkt_full;
			default: pend_bit = 1'b0;
		endcase
		unique case (cw.lst)
			ucrr_pkg::LS_ONE: last_bit = 1'b1;
			ucrr_pkg::LS_FIN: last_bit = fin;
			default: last_bit = 1'b0;
		endcase
		unique case (cw.dsrc)
			ucrr_pkg::DS_CFG: data_bit = cfg_q;
			ucrr_pkg::DS_ROM: data_bit = ucrr_pkg::rom_byte(ptr_q, vend_code_q, prod_code_q);
			default: data_bit = 8'h00;
		endcase
		cfg_nx = cfg_q;
		addr_nx = addr_q;
		aen_nx = aen_q;
		unique case (cw.wr)
			ucrr_pkg::WR_CLEAR: begin
				cfg_nx = 8'h00;
				addr_nx = 7'h00;
				aen_nx = 1'b0;
			end
			ucrr_pkg::WR_ADDR: begin
				addr_nx = val_q[6:0];
				aen_nx = 1'b1;
			end
			ucrr_pkg::WR_CFG: begin
				cfg_nx = val_q;
			end
			default: begin
				cfg_nx = cfg_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= ucrr_pkg::UA_DISPATCH;
			cfg_q <= 8'h00;
			addr_q <= 7'h00;
			aen_q <= 1'b0;
		end else begin
			if (pc_q == ucrr_pkg::UA_DISPATCH) begin
				if (in_acc) begin
					pc_q <= entry;
				end
			end else if (fire) begin
				cfg_q <= cfg_nx;
				addr_q <= addr_nx;
				aen_q <= aen_nx;
				unique case (cw.nxt)
					ucrr_pkg::NX_NEXT: pc_q <= pc_q + ucrr_pkg::PC_W'(1);
					ucrr_pkg::NX_LOOP: pc_q <= fin ? ucrr_pkg::UA_DISPATCH : pc_q;
					default: pc_q <= ucrr_pkg::UA_DISPATCH;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			val_q <= req.req_value[7:0];
			cnt_q <= dcnt;
			ptr_q <= dbase;
			pkt_q <= '0;
		end else if (fire && cw.dsrc == ucrr_pkg::DS_ROM) begin
			cnt_q <= cnt_q - ucrr_pkg::CNT_W'(1);
			ptr_q <= ptr_q + ucrr_pkg::PTR_W'(1);
			pkt_q <= pend_bit ? '0 : pkt_q + ucrr_pkg::PKT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (fire) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			kind_q <= cw.kind;
			data_q <= data_bit;
			pend_q <= pend_bit;
			last_q <= last_bit;
			addr_out_q <= addr_nx;
			aen_out_q <= aen_nx;
			cfg_out_q <= cfg_nx;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.kind = kind_q;
	assign rsp.data_byte = data_q;
	assign rsp.packet_end = pend_q;
	assign rsp.last = last_q;
	assign rsp.device_address = addr_out_q;
	assign rsp.address_enabled = aen_out_q;
	assign rsp.config_value = cfg_out_q;

endmodule

[hdl/ucrr_checker.sv]
// ----------------------------------------------------------------------------
// ucrr_checker
// Port-level checks on the response channel, bound to the top level.
// ----------------------------------------------------------------------------
module ucrr_checker (
	input logic clk,
	input logic arst_n,
	input logic rsp_valid,
	input logic rsp_ready,
	input logic [1:0] kind,
	input logic [7:0] data_byte,
	input logic packet_end,
	input logic last,
	input logic [6:0] device_address,
	input logic address_enabled
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(kind) && $stable(data_byte)
		&& $stable(last))
		else $error("Response changed while stalled.");

	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && kind == ucrr_pkg::KIND_STALL |-> last && !packet_end
		&& data_byte == 8'h00)
		else $error("Stall must be a single result without packet end.");

	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && kind == ucrr_pkg::KIND_DONE |-> last && !packet_end)
		else $error("Completion without data must be the final result.");

	a_final: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && kind == ucrr_pkg::KIND_DATA && last |-> packet_end)
		else $error("The final data byte must close its packet.");

	a_addr: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !address_enabled |-> device_address == 7'h00)
		else $error("An address is reported without being enabled.");

endmodule

bind usb_control_request_responder_unit ucrr_checker u_ucrr_checker (
	.clk(clk),
	.arst_n(arst_n),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.kind(rsp.kind),
	.data_byte(rsp.data_byte),
	.packet_end(rsp.packet_end),
	.last(rsp.last),
	.device_address(rsp.device_address),
	.address_enabled(rsp.address_enabled)
);
